[hdl/ncl_pkg.sv]
// ----------------------------------------------------------------------------
// Noise channel package
// Shared constants, codes and helper functions for the noise channel block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncl_pkg;

  // Default bus address of the first of the four channel registers.
  localparam int unsigned BASE_ADDRESS_DEFAULT = 65312;

  localparam int unsigned COUNT_W = 22;
  localparam int unsigned SHIFT_W = 15;

  // Item opcodes.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register offsets from the base address.
  localparam logic [1:0] REG_LENGTH   = 2'd0;
  localparam logic [1:0] REG_ENVELOPE = 2'd1;
  localparam logic [1:0] REG_POLY     = 2'd2;
  localparam logic [1:0] REG_CONTROL  = 2'd3;

  localparam logic [SHIFT_W-1:0] SHIFT_SEED    = 15'h7FFF;
  localparam logic [COUNT_W-1:0] COUNT_RESET   = 22'd8;
  localparam logic [7:0]         TRIGGER_MASK  = 8'h80;
  localparam logic [7:0]         WIDTH_MODE    = 8'h08;

  typedef logic [6:0] divisor_t;
  localparam divisor_t DIVISORS [8] = '{
    7'd8, 7'd16, 7'd32, 7'd48, 7'd64, 7'd80, 7'd96, 7'd112
  };

  // Status of the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

  // Timer period selected by the poly register.
  function automatic logic [COUNT_W-1:0] period_of(input logic [7:0] poly);
    logic [COUNT_W-1:0] base;
    base = {{(COUNT_W-7){1'b0}}, DIVISORS[poly[2:0]]};
    return base << poly[7:4];
  endfunction

  // One step of the shift register, with the optional 7-bit width mode.
  function automatic logic [SHIFT_W-1:0] lfsr_step(input logic [SHIFT_W-1:0] s,
                                                   input logic short_mode);
    logic fb;
    logic [SHIFT_W-1:0] n;
    fb = s[0] ^ s[1];
    n  = {fb, s[SHIFT_W-1:1]};
    if (short_mode) begin
      n = {8'd0, fb, n[5:0]};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[hdl/ncl_in_if.sv]
// ----------------------------------------------------------------------------
// Noise channel request interface
// Valid/ready channel carrying one register access or time tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic [7:0]  tick_count;

  modport source (output valid, output opcode, output bus_address,
                  output write_data, output tick_count, input ready);
  modport sink   (input valid, input opcode, input bus_address,
                  input write_data, input tick_count, output ready);
endinterface

`default_nettype wire

[hdl/ncl_out_if.sv]
// ----------------------------------------------------------------------------
// Noise channel response interface
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       address_hit;
  logic       noise_bit;
  logic       trigger_pulse;

  modport source (output valid, output read_data, output address_hit,
                  output noise_bit, output trigger_pulse, input ready);
  modport sink   (input valid, input read_data, input address_hit,
                  input noise_bit, input trigger_pulse, output ready);
endinterface

`default_nettype wire

[hdl/ncl_rem.sv]
// ----------------------------------------------------------------------------
// Noise channel remainder unit
// Restoring remainder of an 8-bit count by the timer period, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ncl_rem (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [7:0]                   dividend,
  input  wire logic [ncl_pkg::COUNT_W-1:0]  divisor,
  output ncl_pkg::rem_status_t              status,
  output logic [7:0]                        remainder
);

  logic       busy;
  logic       done;
  logic [2:0] count;
  logic [7:0] bits;
  logic [7:0] r;

  logic [8:0] trial;
  logic       fits;

  // The partial remainder stays below the divisor, so one compare and
  // subtract per bit is enough.
  assign trial = {r, bits[7]};
  assign fits  = {{(ncl_pkg::COUNT_W-9){1'b0}}, trial} >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 3'd0;
        bits  <= dividend;
        r     <= 8'd0;
      end else if (busy) begin
        bits  <= {bits[6:0], 1'b0};
        r     <= fits ? 8'(trial - divisor[8:0]) : trial[7:0];
        count <= count + 3'd1;
        if (count == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status    = '{busy: busy, done: done};
  assign remainder = r;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("remainder done without a running divide");
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    busy && !$past(start) |-> {{(ncl_pkg::COUNT_W-8){1'b0}}, r} < divisor)
    else $error("partial remainder reached the divisor");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("divide started while busy");
`endif

endmodule

`default_nettype wire

[hdl/noise_channel_lfsr_timer.sv]
// ----------------------------------------------------------------------------
// Noise channel LFSR and timer
// Register file, 15-bit noise shift register and period countdown timer.
// ----------------------------------------------------------------------------
//  Channel    Direction  Handshake     Payload
//  request    in         valid/ready   opcode, bus_address, write_data,
//                                      tick_count
//  response   out        valid/ready   read_data, address_hit, noise_bit,
//                                      trigger_pulse
//
// Reads, writes and ticks that do not reach the timer go from S_IDLE to S_DONE.
// A tick that reaches the timer passes S_DIVIDE first: the reload remainder
// comes from a compare-and-subtract unit working one bit per cycle.
// Synchronous reset clears the registers, seeds the shift register and
// loads the countdown with the period for a zero poly register.
// A finished result waits in the output register; the next transaction is
// taken meanwhile and holds in its final state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_channel_lfsr_timer #(
  parameter int unsigned BASE_ADDRESS = ncl_pkg::BASE_ADDRESS_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ncl_in_if.sink       request,
  ncl_out_if.source    response
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIVIDE = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0] state;

  logic [7:0] length_reg;
  logic [7:0] envelope_reg;
  logic [7:0] poly_reg;
  logic [7:0] control_reg;
  logic [ncl_pkg::SHIFT_W-1:0] noise_shift;
  logic [ncl_pkg::COUNT_W-1:0] countdown;

  logic [7:0] res_read_data;
  logic       res_hit;
  logic       res_trigger;

  logic       out_valid;
  logic [7:0] out_read_data;
  logic       out_hit;
  logic       out_noise;
  logic       out_trigger;
  logic       out_load;

  logic                        accept;
  logic [16:0]                 offset;
  logic                        in_range;
  logic [1:0]                  sel;
  logic [7:0]                  sel_data;
  logic                        read_hit;
  logic                        access_hit;
  logic                        trigger_write;
  logic [ncl_pkg::COUNT_W-1:0] period;
  logic [ncl_pkg::COUNT_W-1:0] clocks;
  logic                        reached;
  logic                        tick_reached;
  logic                        rem_start;
  logic [7:0]                  overshoot;
  ncl_pkg::rem_status_t        rem_status;
  logic [7:0]                  rem_value;

  assign accept   = request.valid && request.ready;
  assign offset   = {1'b0, request.bus_address} - 17'(BASE_ADDRESS);
  assign in_range = (offset[16:2] == 15'd0);
  assign sel      = offset[1:0];
  assign period   = ncl_pkg::period_of(poly_reg);
  assign clocks   = {{(ncl_pkg::COUNT_W-8){1'b0}}, request.tick_count};
  assign reached  = clocks >= countdown;
  // Only used when the count reached the timer, so countdown fits 8 bits.
  assign overshoot = request.tick_count - countdown[7:0];

  assign read_hit      = (request.opcode == ncl_pkg::OP_READ) && in_range;
  assign access_hit    = ((request.opcode == ncl_pkg::OP_READ) ||
                          (request.opcode == ncl_pkg::OP_WRITE)) && in_range;
  assign trigger_write = (request.opcode == ncl_pkg::OP_WRITE) && in_range &&
                         (sel == ncl_pkg::REG_CONTROL) &&
                         ((request.write_data & ncl_pkg::TRIGGER_MASK) != 8'd0);
  assign tick_reached  = (request.opcode == ncl_pkg::OP_TICK) && reached;
  assign rem_start     = accept && tick_reached;
  assign out_load      = (state == S_DONE) && (!out_valid || response.ready);

  always_comb begin
    case (sel)
      ncl_pkg::REG_LENGTH:   sel_data = length_reg;
      ncl_pkg::REG_ENVELOPE: sel_data = envelope_reg;
      ncl_pkg::REG_POLY:     sel_data = poly_reg;
      default:               sel_data = control_reg;
    endcase
  end

  ncl_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (overshoot),
    .divisor   (period),
    .status    (rem_status),
    .remainder (rem_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      length_reg   <= 8'd0;
      envelope_reg <= 8'd0;
      poly_reg     <= 8'd0;
      control_reg  <= 8'd0;
      noise_shift  <= ncl_pkg::SHIFT_SEED;
      countdown    <= ncl_pkg::COUNT_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (response.valid && response.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_read_data <= read_hit ? sel_data : 8'd0;
            res_hit       <= access_hit;
            res_trigger   <= trigger_write;
            state         <= tick_reached ? S_DIVIDE : S_DONE;
            case (request.opcode)
              ncl_pkg::OP_WRITE: begin
                if (in_range) begin
                  case (sel)
                    ncl_pkg::REG_LENGTH:   length_reg   <= request.write_data;
                    ncl_pkg::REG_ENVELOPE: envelope_reg <= request.write_data;
                    ncl_pkg::REG_POLY:     poly_reg     <= request.write_data;
                    default: begin
                      control_reg <= request.write_data;
                      if (trigger_write) begin
                        countdown   <= period;
                        noise_shift <= ncl_pkg::SHIFT_SEED;
                      end
                    end
                  endcase
                end
              end
              ncl_pkg::OP_TICK: begin
                if (reached) begin
                  noise_shift <= ncl_pkg::lfsr_step(noise_shift,
                    (poly_reg & ncl_pkg::WIDTH_MODE) != 8'd0);
                end else begin
                  countdown <= countdown - clocks;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIVIDE: begin
          if (rem_status.done) begin
            countdown <= period - {{(ncl_pkg::COUNT_W-8){1'b0}}, rem_value};
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_read_data <= res_read_data;
            out_hit       <= res_hit;
            out_noise     <= ~noise_shift[0];
            out_trigger   <= res_trigger;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign request.ready          = (state == S_IDLE);
  assign response.valid         = out_valid;
  assign response.read_data     = out_read_data;
  assign response.address_hit   = out_hit;
  assign response.noise_bit     = out_noise;
  assign response.trigger_pulse = out_trigger;

`ifndef NO_ASSERTIONS
  a_countdown_nonzero: assert property (@(posedge clk) disable iff (rst)
    countdown != '0) else $error("countdown reached zero");
  a_ready_unit_idle: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !rem_status.busy) else $error("ready while divide runs");
  a_trigger_hits: assert property (@(posedge clk) disable iff (rst)
    response.valid && response.trigger_pulse |-> response.address_hit)
    else $error("trigger reported without an address hit");
  a_divide_started: assert property (@(posedge clk) disable iff (rst)
    state == S_DIVIDE |-> rem_status.busy || rem_status.done)
    else $error("waiting for a divide that is not running");
`endif

endmodule

`default_nettype wire

[tb/tb_noise_channel_lfsr_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Noise channel LFSR and timer testbench
// Sends register reads, writes and time ticks through the request channel
// and compares every response field by field with its fixed table row, if
// any, else with a software copy of the channel: register file, shift
// register stepping, 7-bit mode and timer reload. The table covers the edge
// cases and is followed by random traffic with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_noise_channel_lfsr_timer;

  localparam logic [15:0] REG_BASE     = 16'(ncl_pkg::BASE_ADDRESS_DEFAULT);
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 725;
  localparam int unsigned HOLD_AFTER   = 100;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned STEP_DIVISORS [8] = '{8, 16, 32, 48, 64, 80, 96, 112};
  localparam int unsigned SEND_IDLE [3] = '{8, 56, 0};
  localparam int unsigned RECV_IDLE [3] = '{56, 8, 0};

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic [7:0]  tick_count;
  } noise_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       address_hit;
    logic       noise_bit;
    logic       trigger_pulse;
  } noise_rsp_t;

  typedef struct packed {
    noise_req_t req;
    logic       has_fixed;
    noise_rsp_t rsp;
  } probe_row_t;

  localparam int unsigned NUM_PROBES = 25;
  localparam probe_row_t PROBES [NUM_PROBES] = '{
    '{'{ncl_pkg::OP_READ,  REG_BASE,         8'h00, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_READ,  REG_BASE + 16'd2, 8'hFF, 8'hFF}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_READ,  REG_BASE + 16'd3, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_READ,  REG_BASE - 16'd1, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_READ,  REG_BASE + 16'd4, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_WRITE, 16'hFFFF,         8'hAA, 8'h55}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_WRITE, REG_BASE,         8'hFF, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_WRITE, REG_BASE + 16'd1, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_READ,  REG_BASE,         8'h00, 8'h00}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_READ,  REG_BASE + 16'd1, 8'h00, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    // The timer starts at eight, so these two ticks stop just short of it.
    '{'{ncl_pkg::OP_TICK,  16'h0000,         8'h00, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_TICK,  16'h0000,         8'h00, 8'h07}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_TICK,  REG_BASE,         8'h00, 8'h01}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_TICK,  16'h0000,         8'h00, 8'hFF}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_WRITE, REG_BASE + 16'd2, 8'h08, 8'h00}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_TICK,  16'h0000,         8'h00, 8'hFF}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_WRITE, REG_BASE + 16'd3, 8'h80, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{'{ncl_pkg::OP_WRITE, REG_BASE + 16'd3, 8'h7F, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_WRITE, REG_BASE + 16'd2, 8'hF7, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_WRITE, REG_BASE + 16'd3, 8'hFF, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}},
    '{'{ncl_pkg::OP_TICK,  16'hFFFF,         8'hFF, 8'hFF}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{OP_SPARE,          REG_BASE + 16'd3, 8'hFF, 8'hFF}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
    // A new poly value leaves the long countdown in place until the next reload.
    '{'{ncl_pkg::OP_WRITE, REG_BASE + 16'd2, 8'h00, 8'h00}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_TICK,  16'h0000,         8'h00, 8'hFF}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{'{ncl_pkg::OP_WRITE, REG_BASE + 16'd3, 8'h80, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  ncl_in_if  req_if ();
  ncl_out_if rsp_if ();

  noise_channel_lfsr_timer #(.BASE_ADDRESS(ncl_pkg::BASE_ADDRESS_DEFAULT)) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_if),
    .response (rsp_if)
  );

  logic [7:0]  length_q;
  logic [7:0]  envelope_q;
  logic [7:0]  poly_q;
  logic [7:0]  control_q;
  logic [14:0] shift_q;
  logic [21:0] countdown_q;

  noise_rsp_t  awaited_rsp [$];
  int unsigned idle_phase   = 0;
  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  int unsigned lfsr_steps   = 0;
  int unsigned short_steps  = 0;
  int unsigned triggers     = 0;
  int unsigned hold_left    = 0;

  function automatic int unsigned timer_period(input logic [7:0] poly);
    return STEP_DIVISORS[poly[2:0]] << poly[7:4];
  endfunction

  // Applies one transaction to the channel copy and returns its response.
  function automatic noise_rsp_t advance_channel(input noise_req_t item);
    noise_rsp_t  rsp;
    logic        mapped;
    logic [1:0]  offset;
    int unsigned period;
    int unsigned overshoot;
    logic        feedback;
    rsp    = '0;
    mapped = item.bus_address >= REG_BASE && item.bus_address <= REG_BASE + 16'd3;
    offset = 2'(item.bus_address - REG_BASE);
    period = timer_period(poly_q);
    case (item.opcode)
      ncl_pkg::OP_READ: begin
        if (mapped) begin
          rsp.address_hit = 1'b1;
          case (offset)
            ncl_pkg::REG_LENGTH:   rsp.read_data = length_q;
            ncl_pkg::REG_ENVELOPE: rsp.read_data = envelope_q;
            ncl_pkg::REG_POLY:     rsp.read_data = poly_q;
            default:               rsp.read_data = control_q;
          endcase
        end
      end
      ncl_pkg::OP_WRITE: begin
        if (mapped) begin
          rsp.address_hit = 1'b1;
          case (offset)
            ncl_pkg::REG_LENGTH:   length_q = item.write_data;
            ncl_pkg::REG_ENVELOPE: envelope_q = item.write_data;
            ncl_pkg::REG_POLY:     poly_q = item.write_data;
            default: begin
              if ((item.write_data & ncl_pkg::TRIGGER_MASK) != 0) begin
                countdown_q = 22'(period);
                shift_q     = ncl_pkg::SHIFT_SEED;
                rsp.trigger_pulse = 1'b1;
                triggers++;
              end
              control_q = item.write_data;
            end
          endcase
        end
      end
      ncl_pkg::OP_TICK: begin
        if (item.tick_count >= countdown_q) begin
          feedback    = shift_q[0] ^ shift_q[1];
          shift_q     = shift_q >> 1;
          shift_q[14] = feedback;
          if ((poly_q & ncl_pkg::WIDTH_MODE) != 0) begin
            // In 7-bit mode the feedback lands in bit 6 and the upper bits are lost.
            shift_q[14:7] = '0;
            shift_q[6]    = feedback;
            short_steps++;
          end
          overshoot   = item.tick_count - countdown_q;
          countdown_q = 22'(period - overshoot % period);
          lfsr_steps++;
        end else begin
          countdown_q = countdown_q - item.tick_count;
        end
      end
      default: ;
    endcase
    rsp.noise_bit = ~shift_q[0];
    return rsp;
  endfunction

  task automatic offer(input noise_req_t item, input logic has_fixed,
                       input noise_rsp_t fixed_rsp);
    noise_rsp_t predicted;
    while ($urandom_range(0, 99) < SEND_IDLE[idle_phase]) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= item.opcode;
    req_if.bus_address <= item.bus_address;
    req_if.write_data  <= item.write_data;
    req_if.tick_count  <= item.tick_count;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = advance_channel(item);
    awaited_rsp.push_back(has_fixed ? fixed_rsp : predicted);
  endtask

  initial begin
    noise_rsp_t  none_rsp;
    noise_req_t  item;
    int unsigned pick;
    int unsigned drain;
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.opcode      <= ncl_pkg::OP_READ;
    req_if.bus_address <= '0;
    req_if.write_data  <= '0;
    req_if.tick_count  <= '0;
    length_q    = '0;
    envelope_q  = '0;
    poly_q      = '0;
    control_q   = '0;
    shift_q     = ncl_pkg::SHIFT_SEED;
    countdown_q = ncl_pkg::COUNT_RESET;
    none_rsp    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (PROBES[i]) offer(PROBES[i].req, PROBES[i].has_fixed, PROBES[i].rsp);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS * 2 / 3) begin
        // Let every outstanding response drain before the gap-free phase.
        req_if.valid <= 1'b0;
        do @(posedge clk); while (awaited_rsp.size() != 0);
      end
      idle_phase       = n * 3 / RANDOM_ITEMS;
      item.opcode      = ncl_pkg::OP_TICK;
      item.bus_address = 16'($urandom);
      item.write_data  = 8'($urandom);
      item.tick_count  = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        item.opcode = 2'($urandom);
      end else if (pick < 45) begin
        if ($urandom_range(0, 3) == 0) item.tick_count = 8'($urandom_range(0, 15));
      end else if (pick < 65) begin
        item.opcode      = ncl_pkg::OP_READ;
        item.bus_address = REG_BASE + 16'($urandom_range(0, 3));
      end else if (pick < 90) begin
        item.opcode      = ncl_pkg::OP_WRITE;
        item.bus_address = REG_BASE + 16'($urandom_range(0, 3));
        // Keep most periods short so that ticks keep stepping the shift register.
        if (item.bus_address == REG_BASE + 16'(ncl_pkg::REG_POLY) &&
            $urandom_range(0, 9) != 0) begin
          item.write_data[7:4] = 4'($urandom_range(0, 1));
        end
      end else begin
        item.opcode        = ncl_pkg::OP_WRITE;
        item.bus_address   = REG_BASE + 16'(ncl_pkg::REG_CONTROL);
        item.write_data[7] = 1'b1;
      end
      offer(item, 1'b0, none_rsp);
    end

    req_if.valid <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (awaited_rsp.size() != 0 && drain < DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_rsp.size() != 0) begin
      $error("%0d responses never arrived", awaited_rsp.size());
      error_count++;
    end
    $display("Checked %0d responses with %0d triggers and %0d shift register steps,",
             results_seen, triggers, lfsr_steps);
    $display("%0d of them in 7-bit mode, under three idle patterns and one long stall.",
             short_steps);
    if (error_count == 0) begin
      $display("noise_channel_lfsr_timer: match");
    end else begin
      $display("noise_channel_lfsr_timer: mismatch");
    end
    $finish;
  end

  // Response side: checks each transaction and decides ready for the next cycle.
  always @(posedge clk) begin
    noise_rsp_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (awaited_rsp.size() == 0) begin
          $error("response with no transaction outstanding");
          error_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_if.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, rsp_if.read_data);
            error_count++;
          end
          if (rsp_if.address_hit !== want.address_hit) begin
            $error("address_hit: expected %0b, got %0b", want.address_hit,
                   rsp_if.address_hit);
            error_count++;
          end
          if (rsp_if.noise_bit !== want.noise_bit) begin
            $error("noise_bit: expected %0b, got %0b", want.noise_bit, rsp_if.noise_bit);
            error_count++;
          end
          if (rsp_if.trigger_pulse !== want.trigger_pulse) begin
            $error("trigger_pulse: expected %0b, got %0b", want.trigger_pulse,
                   rsp_if.trigger_pulse);
            error_count++;
          end
        end
        if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= RECV_IDLE[idle_phase]);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("noise_channel_lfsr_timer: mismatch");
    $finish;
  end

endmodule

[sim.f]
hdl/ncl_pkg.sv
hdl/ncl_in_if.sv
hdl/ncl_out_if.sv
hdl/ncl_rem.sv
hdl/noise_channel_lfsr_timer.sv
tb/tb_noise_channel_lfsr_timer.sv
